[rtl/sslfp_pkg.sv]
`default_nettype none

package sslfp_pkg;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned ROLE_W       = 4;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned CSR_INDEX_W  = 8;

   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCOUNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] START_SYM = 8'd2;
   localparam logic [BYTE_W-1:0] STOP_SYM  = 8'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_SYMBOL = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_SYMBOL  = 8'd1;

   // Index of the last header byte (the length byte).
   localparam logic [ROLE_W-1:0] HEADER_LAST  = 4'd10;
   localparam logic [ROLE_W-1:0] ROLE_NONE    = 4'd0;
   localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 4'd12;

   typedef enum logic [STATUS_W-1:0] {
      ST_BUSY     = 2'd0,
      ST_OK       = 2'd1,
      ST_NOSTART  = 2'd2,
      ST_MISMATCH = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_HEADER  = 3'd1,
      PH_PAYLOAD = 3'd2,
      PH_STOP    = 3'd3,
      PH_DISCARD = 3'd4
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [ROLE_W-1:0] role;
      logic [BYTE_W-1:0] index;
      status_type        status;
      logic              done;
   } entry_type;

endpackage

`default_nettype wire

[rtl/sslfp_front.sv]
`default_nettype none

module sslfp_front
   import sslfp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]      csr_wdata,
   input  wire logic                   accept,
   input  wire logic [BYTE_W-1:0]      rx_byte,
   input  wire logic                   packet_end,
   output entry_type                   entry
);

   logic [BYTE_W-1:0] open_byte_ff, open_byte_in;
   logic [BYTE_W-1:0] close_byte_ff, close_byte_in;
   phase_type         phase_ff, phase_in;
   logic [ROLE_W-1:0] hpos_ff, hpos_in;
   logic [BYTE_W-1:0] remain_ff, remain_in;
   logic [BYTE_W-1:0] ppos_ff, ppos_in;

   assign csr_ready = 1'b1;

   always_comb begin
      open_byte_in  = open_byte_ff;
      close_byte_in = close_byte_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_START_SYMBOL: open_byte_in  = csr_wdata;
            CSR_STOP_SYMBOL:  close_byte_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      entry.data   = rx_byte;
      entry.role   = ROLE_NONE;
      entry.index  = '0;
      entry.status = ST_BUSY;
      entry.done   = 1'b0;
      phase_in     = phase_ff;
      hpos_in      = hpos_ff;
      remain_in    = remain_ff;
      ppos_in      = ppos_ff;

      unique case (phase_ff)
         PH_START: begin
            if (rx_byte == open_byte_ff) begin
               hpos_in   = '0;
               ppos_in   = '0;
               remain_in = '0;
               phase_in  = PH_HEADER;
            end else begin
               entry.status = ST_NOSTART;
               entry.done   = 1'b1;
               phase_in     = PH_DISCARD;
            end
         end
         PH_HEADER: begin
            entry.role = hpos_ff + 4'd1;
            if (hpos_ff >= HEADER_LAST) begin
               // The length byte sets up the payload count.
               remain_in = rx_byte;
               ppos_in   = '0;
               phase_in  = (rx_byte != '0) ? PH_PAYLOAD : PH_STOP;
            end else begin
               hpos_in = hpos_ff + 4'd1;
            end
         end
         PH_PAYLOAD: begin
            entry.role  = ROLE_PAYLOAD;
            entry.index = ppos_ff;
            ppos_in     = ppos_ff + 8'd1;
            remain_in   = remain_ff - 8'd1;
            if (remain_ff == 8'd1) begin
               phase_in = PH_STOP;
            end
         end
         PH_STOP: begin
            entry.status = (rx_byte == close_byte_ff) ? ST_OK : ST_MISMATCH;
            entry.done   = 1'b1;
            phase_in     = PH_DISCARD;
         end
         default: ;
      endcase

      // A packet that ends before its stop byte is a length mismatch.
      if (packet_end) begin
         if (!entry.done && (phase_ff == PH_HEADER || phase_ff == PH_PAYLOAD ||
                             phase_ff == PH_START)) begin
            entry.status = ST_MISMATCH;
            entry.done   = 1'b1;
         end
         phase_in = PH_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_byte_ff  <= START_SYM;
         close_byte_ff <= STOP_SYM;
         phase_ff      <= PH_START;
         hpos_ff       <= '0;
         remain_ff     <= '0;
         ppos_ff       <= '0;
      end else begin
         open_byte_ff  <= open_byte_in;
         close_byte_ff <= close_byte_in;
         if (accept) begin
            phase_ff  <= phase_in;
            hpos_ff   <= hpos_in;
            remain_ff <= remain_in;
            ppos_ff   <= ppos_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_discard_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_DISCARD) |-> (entry.role == ROLE_NONE && !entry.done))
      else $error("byte in discard phase was not silently dropped");

   a_header_bounded: assert property (@(posedge clock) disable iff (reset)
      hpos_ff <= HEADER_LAST)
      else $error("header position ran past the length byte");
`endif

endmodule

`default_nettype wire

[rtl/sslfp_queue.sv]
`default_nettype none

module sslfp_queue
   import sslfp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      wr_en,
   input  wire entry_type wr_data,
   output logic           full,
   input  wire logic      rd_en,
   output entry_type      rd_data,
   output logic           rd_valid
);

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wr_en ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = rd_en ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCOUNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds its depth");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !rd_en) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a write");
`endif

endmodule

`default_nettype wire

[rtl/sslfp_back.sv]
`default_nettype none

module sslfp_back
   import sslfp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           q_valid,
   input  wire entry_type      q_data,
   output logic                q_read,
   input  wire logic           pop,
   output logic                empty,
   output logic [BYTE_W-1:0]   out_byte,
   output logic [ROLE_W-1:0]   byte_role,
   output logic [BYTE_W-1:0]   payload_index,
   output logic [STATUS_W-1:0] frame_status,
   output logic                frame_done
);

   logic              valid_ff, valid_in;
   entry_type         rsp_ff;
   logic              taken;

   assign taken  = pop && valid_ff;
   // The output register reloads in the same cycle as it is emptied.
   assign q_read = q_valid && (!valid_ff || taken);

   always_comb begin
      valid_in = valid_ff;
      if (q_read) begin
         valid_in = 1'b1;
      end else if (taken) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_read) begin
         rsp_ff <= q_data;
      end
   end

   assign empty         = !valid_ff;
   // Bytes without a role are output as zero.
   assign out_byte      = (rsp_ff.role != ROLE_NONE) ? rsp_ff.data : '0;
   assign byte_role     = rsp_ff.role;
   assign payload_index = rsp_ff.index;
   assign frame_status  = rsp_ff.status;
   assign frame_done    = rsp_ff.done;

`ifndef SYNTHESIS
   a_refill: assert property (@(posedge clock) disable iff (reset)
      (q_valid && !valid_ff) |=> valid_ff)
      else $error("output register did not take a waiting result");

   a_no_read_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_read |-> q_valid)
      else $error("read from an empty queue");
`endif

endmodule

`default_nettype wire

[rtl/start_stop_length_frame_parser.sv]
// Frame parser for received radio packets: one byte enters per cycle while full
// is low, and each byte yields one result tagging it as header field, payload
// byte or dropped, with the frame status when the frame's handling ends. A byte
// is tagged in the cycle of its transfer on the request side and written into
// the four-entry queue, from which the output register takes its result. The
// sustained rate of one byte per cycle is set by the parser updating its state
// on each accepted byte. Up to five results are held (four in the queue, one
// in the output register) before full rises. Start and stop symbols are
// written through the csr_ port and apply to the next byte.
`default_nettype none

module start_stop_length_frame_parser
   import sslfp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]      csr_wdata,
   input  wire logic                   push,
   output logic                        full,
   input  wire logic [BYTE_W-1:0]      req_rx_byte,
   input  wire logic                   req_packet_end,
   output logic                        empty,
   input  wire logic                   pop,
   output logic [BYTE_W-1:0]           rsp_out_byte,
   output logic [ROLE_W-1:0]           rsp_byte_role,
   output logic [BYTE_W-1:0]           rsp_payload_index,
   output logic [STATUS_W-1:0]         rsp_frame_status,
   output logic                        rsp_frame_done
);

   logic      accept;
   entry_type entry;
   logic      q_read;
   logic      q_valid;
   entry_type q_data;

   assign accept = push && !full;

   sslfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .packet_end (req_packet_end),
      .entry      (entry)
   );

   sslfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept),
      .wr_data  (entry),
      .full     (full),
      .rd_en    (q_read),
      .rd_data  (q_data),
      .rd_valid (q_valid)
   );

   sslfp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_data        (q_data),
      .q_read        (q_read),
      .pop           (pop),
      .empty         (empty),
      .out_byte      (rsp_out_byte),
      .byte_role     (rsp_byte_role),
      .payload_index (rsp_payload_index),
      .frame_status  (rsp_frame_status),
      .frame_done    (rsp_frame_done)
   );

endmodule

`default_nettype wire

[sim/frame_tag_checker.sv]
`timescale 1ns / 1ps

module frame_tag_checker
   import sslfp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]      csr_wdata,
   input  wire logic                   push,
   input  wire logic                   full,
   input  wire logic [BYTE_W-1:0]      req_rx_byte,
   input  wire logic                   req_packet_end,
   input  wire logic                   empty,
   input  wire logic                   pop,
   input  wire logic [BYTE_W-1:0]      rsp_out_byte,
   input  wire logic [ROLE_W-1:0]      rsp_byte_role,
   input  wire logic [BYTE_W-1:0]      rsp_payload_index,
   input  wire logic [STATUS_W-1:0]    rsp_frame_status,
   input  wire logic                   rsp_frame_done,
   output int                          error_count,
   output int                          tags_outstanding
);

   logic [BYTE_W-1:0] open_byte  = START_SYM;
   logic [BYTE_W-1:0] close_byte = STOP_SYM;

   phase_type         phase    = PH_START;
   logic [ROLE_W-1:0] hdr_pos  = '0;
   logic [BYTE_W-1:0] pay_left = '0;
   logic [BYTE_W-1:0] pay_pos  = '0;

   entry_type expected_tags[$];
   entry_type got;
   entry_type want;
   int        errors_seen = 0;

   initial tags_outstanding = 0;

   assign error_count = errors_seen;

   // Advances the parser state by one byte and returns the tag it should carry.
   function automatic entry_type tag_byte(input logic [BYTE_W-1:0] b, input logic last);
      entry_type r;
      phase_type nxt;
      r        = '0;
      r.status = ST_BUSY;
      nxt      = phase;
      case (phase)
         PH_START: begin
            if (b == open_byte) begin
               hdr_pos  = '0;
               pay_pos  = '0;
               pay_left = '0;
               nxt      = PH_HEADER;
            end else begin
               r.status = ST_NOSTART;
               r.done   = 1'b1;
               nxt      = PH_DISCARD;
            end
         end
         PH_HEADER: begin
            r.role = hdr_pos + 4'd1;
            if (hdr_pos >= HEADER_LAST) begin
               // The length byte closes the header.
               pay_left = b;
               pay_pos  = '0;
               nxt      = (b != 8'd0) ? PH_PAYLOAD : PH_STOP;
            end else begin
               hdr_pos = hdr_pos + 4'd1;
            end
         end
         PH_PAYLOAD: begin
            r.role   = ROLE_PAYLOAD;
            r.index  = pay_pos;
            pay_pos  = pay_pos + 8'd1;
            pay_left = pay_left - 8'd1;
            if (pay_left == 8'd0) nxt = PH_STOP;
         end
         PH_STOP: begin
            r.status = (b == close_byte) ? ST_OK : ST_MISMATCH;
            r.done   = 1'b1;
            nxt      = PH_DISCARD;
         end
         default: ;
      endcase
      if (last) begin
         // A packet that ends before its stop byte is a length mismatch.
         if (!r.done && (phase == PH_START || phase == PH_HEADER ||
                         phase == PH_PAYLOAD)) begin
            r.status = ST_MISMATCH;
            r.done   = 1'b1;
         end
         nxt = PH_START;
      end
      phase  = nxt;
      r.data = (r.role != ROLE_NONE) ? b : '0;
      return r;
   endfunction

   task automatic flag_error(input string what);
      errors_seen++;
      if (errors_seen <= 10) $display("%0t frame_tag_checker: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         open_byte  = START_SYM;
         close_byte = STOP_SYM;
         phase      = PH_START;
         hdr_pos    = '0;
         pay_left   = '0;
         pay_pos    = '0;
         expected_tags.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_START_SYMBOL) open_byte = csr_wdata;
            else if (csr_index == CSR_STOP_SYMBOL) close_byte = csr_wdata;
         end
         if (push && !full) expected_tags.push_back(tag_byte(req_rx_byte, req_packet_end));
         if (pop && !empty) begin
            got.data   = rsp_out_byte;
            got.role   = rsp_byte_role;
            got.index  = rsp_payload_index;
            got.status = status_type'(rsp_frame_status);
            got.done   = rsp_frame_done;
            if (expected_tags.size() == 0) begin
               flag_error($sformatf({"result with no byte outstanding: byte %h role %0d",
                  " index %0d status %0d done %0b"},
                  got.data, got.role, got.index, got.status, got.done));
            end else begin
               want = expected_tags.pop_front();
               if (got.data !== want.data || got.role !== want.role
                   || got.index !== want.index
                   || got.status !== want.status || got.done !== want.done) begin
                  flag_error($sformatf({"mismatch: expected byte %h role %0d index %0d",
                     " status %0d done %0b, got byte %h role %0d index %0d",
                     " status %0d done %0b"},
                     want.data, want.role, want.index, want.status, want.done,
                     got.data, got.role, got.index, got.status, got.done));
               end
            end
         end
      end
      tags_outstanding = expected_tags.size();
   end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import sslfp_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 165;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASE_COUNT     = 5;

   // A register index that the block does not implement.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 8'd7;

   typedef enum {FR_GOOD, FR_BAD_START, FR_BAD_STOP, FR_EARLY_END, FR_NOISE} frame_kind_type;

   logic                   clock;
   logic                   reset          = 1'b1;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [BYTE_W-1:0]      csr_wdata      = '0;
   logic                   push           = 1'b0;
   logic                   full;
   logic [BYTE_W-1:0]      req_rx_byte    = '0;
   logic                   req_packet_end = 1'b0;
   logic                   empty;
   logic                   pop            = 1'b0;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic [ROLE_W-1:0]      rsp_byte_role;
   logic [BYTE_W-1:0]      rsp_payload_index;
   logic [STATUS_W-1:0]    rsp_frame_status;
   logic                   rsp_frame_done;

   int error_count;
   int tags_outstanding;
   int cycle_count = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   int pop_mode    = 0;
   int pop_tick    = 0;

   logic [BYTE_W-1:0] open_byte  = START_SYM;
   logic [BYTE_W-1:0] close_byte = STOP_SYM;

   start_stop_length_frame_parser DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .push              (push),
      .full              (full),
      .req_rx_byte       (req_rx_byte),
      .req_packet_end    (req_packet_end),
      .empty             (empty),
      .pop               (pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_role     (rsp_byte_role),
      .rsp_payload_index (rsp_payload_index),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_frame_done    (rsp_frame_done)
   );

   frame_tag_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .push              (push),
      .full              (full),
      .req_rx_byte       (req_rx_byte),
      .req_packet_end    (req_packet_end),
      .empty             (empty),
      .pop               (pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_role     (rsp_byte_role),
      .rsp_payload_index (rsp_payload_index),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_frame_done    (rsp_frame_done),
      .error_count       (error_count),
      .tags_outstanding  (tags_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // The receiver switches between random stall patterns, one of which never stalls.
   always @(posedge clock) begin
      pop_tick <= pop_tick + 1;
      if (pop_tick % 64 == 63) pop_mode <= $urandom_range(0, 3);
      case (pop_mode)
         0:       pop <= 1'b1;
         1:       pop <= 1'($urandom_range(0, 1));
         2:       pop <= (pop_tick % 8) < 2;
         default: pop <= ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] avoid);
      logic [BYTE_W-1:0] v;
      v = 8'($urandom);
      while (v == avoid) v = 8'($urandom);
      return v;
   endfunction

   // Bytes go out in bursts of random length; a burst may follow the last without a gap.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push           <= 1'b1;
      req_rx_byte    <= b;
      req_packet_end <= last;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_frame(input frame_kind_type kind, input int len);
      logic [BYTE_W-1:0] frame_bytes[$];
      int keep;
      if (kind == FR_NOISE) begin
         repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
      end else begin
         frame_bytes.push_back((kind == FR_BAD_START) ? other_than(open_byte) : open_byte);
         repeat (HEADER_LAST) frame_bytes.push_back(8'($urandom));
         frame_bytes.push_back(8'(len));
         repeat (len) frame_bytes.push_back(8'($urandom));
         frame_bytes.push_back((kind == FR_BAD_STOP) ? other_than(close_byte) : close_byte);
         if (kind == FR_EARLY_END) begin
            // The packet ends somewhere before its stop byte.
            keep = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
         end else if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
         end
      end
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (tags_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   initial begin
      int pick;
      int len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Good frame of zero length, header bytes alternating between the byte extremes.
      send_byte(open_byte, 1'b0);
      for (int i = 0; i < 10; i++) send_byte(i[0] ? 8'hFF : 8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(close_byte, 1'b1);
      // Missing start symbol, then the rest of the packet is dropped.
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      // A packet holding only the start symbol, and one ending inside the header.
      send_byte(open_byte, 1'b1);
      send_byte(open_byte, 1'b0);
      send_byte(8'hA5, 1'b1);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         if (ph > 0) begin
            drain();
            case (ph)
               1: begin open_byte = 8'h00; close_byte = 8'hFF; end
               2: begin open_byte = 8'hFF; close_byte = 8'h00; end
               3: begin open_byte = 8'($urandom); close_byte = 8'($urandom); end
               default: begin open_byte = 8'($urandom); close_byte = open_byte; end
            endcase
            write_reg(CSR_START_SYMBOL, open_byte);
            write_reg(CSR_STOP_SYMBOL, close_byte);
            if (ph == 3) write_reg(CSR_UNUSED, 8'($urandom));
            csr_valid <= 1'b0;
         end
         items_sent = 0;
         if (ph == 2) send_frame(FR_GOOD, 255);
         while (items_sent < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 9);
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            if (pick <= 5)      send_frame(FR_GOOD, len);
            else if (pick == 6) send_frame(FR_BAD_START, len);
            else if (pick == 7) send_frame(FR_BAD_STOP, len);
            else if (pick == 8) send_frame(FR_EARLY_END, len);
            else                send_frame(FR_NOISE, len);
         end
      end

      drain();
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
